// ===== rtl/core/cedly_pkg.sv =====
package cedly_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_BLOCKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY        = 1'b1;

    // Register widths and reset values
    localparam int DELAY_W = 8;
    localparam int DECAY_W = 16;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd64;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd16384;

    // Shortest usable ring length in blocks
    localparam int MIN_BLOCKS = 2;

    // Decay is Q1.15
    localparam int DECAY_FRAC = 15;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_MUL,
        ST_WRITE
    } state_t;

endpackage

// ===== rtl/core/cedly_ram.sv =====
module cedly_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/cascaded_echo_delay_top.sv =====
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+---------------------------------------
// input    | in_valid  | in_stall  | sample_in (signed SAMPLE_WIDTH)
// output   | out_valid | out_stall | sample_out (signed SAMPLE_WIDTH)
// config   | cfg_we    | -         | cfg_index, cfg_data (no wait states)
//
// One item at a time: accept, ring read, multiply, write back. The first sample
// of each block also passes through ST_MOD, the bit-serial modulo that folds both
// block indices into the latched length. After reset the ring RAM is zeroed, one
// entry per cycle, all BLOCK_LEN*MAX_BLOCKS entries; in_stall stays high meanwhile.
// A result waits in the output register; the write-back cycle of the next item holds
// while that register is full and out_stall is high.
module cascaded_echo_delay_top #(
    parameter int BLOCK_LEN    = 512,
    parameter int MAX_BLOCKS   = 128,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample_in,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]        sample_out,
    input  logic                                  cfg_we,
    input  logic [cedly_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cedly_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import cedly_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int DEPTH  = BLOCK_LEN * MAX_BLOCKS;
    localparam int AW     = $clog2(DEPTH);
    localparam int POSW   = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
    // block index may reach MAX_BLOCKS right after the block-end increment
    localparam int BW     = $clog2(MAX_BLOCKS + 1);
    localparam int CNTW   = $clog2(BW);
    localparam int LIMW   = (BW > DELAY_W) ? BW : DELAY_W;
    localparam int PROD_W = SW + DECAY_W + 1;
    localparam int RND_W  = PROD_W + 1;
    localparam int Q_W    = RND_W - DECAY_FRAC;
    localparam int SUM_W  = SW + 2;
    localparam int RAM_W  = 3 * SW;

    localparam logic [SW-1:0]    S_MAX   = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0]    S_MIN   = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SUM_W-1:0] SUM_MAX = {{(SUM_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {{(SUM_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic [Q_W-1:0]   Q_MAX   = {{(Q_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic [Q_W-1:0]   Q_MIN   = {{(Q_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (DECAY_FRAC - 1);

    // Round Q1.15 product to nearest (half up, floor shift) and saturate.
    function automatic logic [SW-1:0] scale_sat(input logic [PROD_W-1:0] prod);
        logic signed [RND_W-1:0] rnd;
        logic signed [Q_W-1:0]   q;
        rnd = $signed({prod[PROD_W-1], prod}) + $signed(RND_HALF);
        q   = Q_W'(rnd >>> DECAY_FRAC);
        if (q > $signed(Q_MAX))
            scale_sat = S_MAX;
        else if (q < $signed(Q_MIN))
            scale_sat = S_MIN;
        else
            scale_sat = q[SW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [DELAY_W-1:0] delay_blocks_reg;
    logic [DECAY_W-1:0] decay_reg;
    logic [BW-1:0]      len_reg;        // latched at block start
    logic [DECAY_W-1:0] decay_lat_reg;  // latched at block start
    logic [BW-1:0]      wblk_reg;
    logic [BW-1:0]      rblk_reg;
    logic [POSW-1:0]    pos_reg;
    logic [AW-1:0]      clr_cnt_reg;

    // bit-serial remainder for both indices
    logic [CNTW-1:0]    mod_cnt_reg;
    logic [BW-1:0]      wq_reg, wr_reg;
    logic [BW-1:0]      rq_reg, rr_reg;

    logic [SW-1:0]      x_reg;
    logic [SW-1:0]      y_reg;
    logic [PROD_W-1:0]  prod_x_reg, prod_a_reg, prod_b_reg;

    logic               out_valid_reg;
    logic [SW-1:0]      sample_out_reg;

    // ------------------------------------------------------------------
    // Ring RAM: {third, second, first} share one address
    // ------------------------------------------------------------------
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [RAM_W-1:0] ram_wdata, ram_rdata;

    cedly_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 wb_go;
    logic                 block_start;
    logic                 pos_last;
    logic [LIMW-1:0]      dly_ext;
    logic [BW-1:0]        len_clamp;
    logic [AW-1:0]        wa, ra;
    logic [BW:0]          wtrial, rtrial;
    logic [BW-1:0]        wr_step, rr_step;
    logic signed [SW-1:0] ring_a, ring_b, ring_c;
    logic signed [SUM_W-1:0] mix_sum;
    logic [SW-1:0]        mix_sat;
    logic signed [PROD_W-1:0] gain_ext;

    assign in_xfer     = in_valid && !in_stall;
    assign out_xfer    = out_valid_reg && !out_stall;
    assign wb_go       = !out_valid_reg || !out_stall;
    assign block_start = (pos_reg == '0);
    assign pos_last    = (pos_reg == POSW'(BLOCK_LEN - 1));

    always_comb
    begin
        dly_ext = LIMW'(delay_blocks_reg);
        if (dly_ext < LIMW'(MIN_BLOCKS))
            len_clamp = BW'(MIN_BLOCKS);
        else if (dly_ext > LIMW'(MAX_BLOCKS))
            len_clamp = BW'(MAX_BLOCKS);
        else
            len_clamp = BW'(dly_ext);
    end

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        wtrial = {wr_reg, wq_reg[BW-1]};
        rtrial = {rr_reg, rq_reg[BW-1]};
        if (wtrial >= {1'b0, len_reg})
            wr_step = BW'(wtrial - {1'b0, len_reg});
        else
            wr_step = BW'(wtrial);
        if (rtrial >= {1'b0, len_reg})
            rr_step = BW'(rtrial - {1'b0, len_reg});
        else
            rr_step = BW'(rtrial);
    end

    assign wa = AW'(wblk_reg) * AW'(BLOCK_LEN) + AW'(pos_reg);
    assign ra = AW'(rblk_reg) * AW'(BLOCK_LEN) + AW'(pos_reg);

    assign ring_a = $signed(ram_rdata[SW-1:0]);
    assign ring_b = $signed(ram_rdata[2*SW-1:SW]);
    assign ring_c = $signed(ram_rdata[3*SW-1:2*SW]);

    // gain as a full-width signed operand so each product keeps all its bits
    assign gain_ext = PROD_W'($signed({1'b0, decay_lat_reg}));

    always_comb
    begin
        mix_sum = SUM_W'($signed(x_reg)) + SUM_W'(ring_a) + SUM_W'(ring_b)
                + SUM_W'(ring_c);
        if (mix_sum > $signed(SUM_MAX))
            mix_sat = S_MAX;
        else if (mix_sum < $signed(SUM_MIN))
            mix_sat = S_MIN;
        else
            mix_sat = mix_sum[SW-1:0];
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = wa;
        ram_raddr  = ra;
        ram_wdata  = {scale_sat(prod_b_reg), scale_sat(prod_a_reg),
                      scale_sat(prod_x_reg)};
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    state_next = block_start ? ST_MOD : ST_READ;
            end
            ST_MOD:
            begin
                if (mod_cnt_reg == '0)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (wb_go)
                begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_blocks_reg <= DELAY_RESET;
            decay_reg        <= DECAY_RESET;
            len_reg          <= BW'(DELAY_RESET);
            decay_lat_reg    <= DECAY_RESET;
            wblk_reg         <= '0;
            rblk_reg         <= BW'(1);
            pos_reg          <= '0;
            clr_cnt_reg      <= '0;
            mod_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DELAY_BLOCKS: delay_blocks_reg <= cfg_data[DELAY_W-1:0];
                    REG_DECAY:        decay_reg        <= cfg_data[DECAY_W-1:0];
                    default:          ;
                endcase
            end

            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);

            // block start: latch settings, then fold indices into new length
            if (in_xfer && block_start)
            begin
                len_reg       <= len_clamp;
                decay_lat_reg <= decay_reg;
                mod_cnt_reg   <= CNTW'(BW - 1);
            end

            if (state_reg == ST_MOD)
            begin
                mod_cnt_reg <= mod_cnt_reg - CNTW'(1);
                if (mod_cnt_reg == '0)
                begin
                    wblk_reg <= wr_step;
                    rblk_reg <= rr_step;
                end
            end

            if (out_xfer)
                out_valid_reg <= 1'b0;

            if (state_reg == ST_WRITE && wb_go)
            begin
                out_valid_reg <= 1'b1;
                if (pos_last)
                begin
                    pos_reg  <= '0;
                    wblk_reg <= wblk_reg + BW'(1);
                    rblk_reg <= rblk_reg + BW'(1);
                end
                else
                begin
                    pos_reg <= pos_reg + POSW'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            x_reg  <= sample_in;
            wq_reg <= wblk_reg;
            rq_reg <= rblk_reg;
            wr_reg <= '0;
            rr_reg <= '0;
        end

        if (state_reg == ST_MOD)
        begin
            wq_reg <= wq_reg << 1;
            rq_reg <= rq_reg << 1;
            wr_reg <= wr_step;
            rr_reg <= rr_step;
        end

        if (state_reg == ST_MUL)
        begin
            y_reg      <= mix_sat;
            prod_x_reg <= PROD_W'($signed(x_reg)) * gain_ext;
            prod_a_reg <= PROD_W'(ring_a) * gain_ext;
            prod_b_reg <= PROD_W'(ring_b) * gain_ext;
        end

        if (state_reg == ST_WRITE && wb_go)
            sample_out_reg <= y_reg;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

// ===== verif/cascaded_echo_delay_top_tb.sv =====
module cascaded_echo_delay_top_tb;

    import cedly_pkg::*;

    localparam int BLOCK_LEN    = 512;
    localparam int MAX_BLOCKS   = 128;
    localparam int SAMPLE_W     = 16;
    localparam int RING_DEPTH   = BLOCK_LEN * MAX_BLOCKS;

    // 8 phases of 260 samples after the 25 warm-up samples; phases 1, 3, 5 and 7
    // each straddle a block start, so their settings are the ones that latch.
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 260;
    localparam int WARM_ROWS    = 25;

    // Each item passes accept, read, multiply and write-back, plus the serial modulo at a block start.
    localparam int SETTLE_CYCLES = 32;
    // The RAM clear after reset covers all RING_DEPTH entries with no transfer.
    localparam int WATCHDOG_LIMIT = 4 * RING_DEPTH;

    localparam longint PCM_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint PCM_MIN = -PCM_MAX - 1;

    typedef logic signed [SAMPLE_W-1:0] pcm_t;

    typedef struct packed {
        pcm_t din;
        pcm_t want;
    } warm_row_t;

    // Right after reset every ring reads zero, so the output is the dry sample.
    localparam warm_row_t WARM_TABLE [WARM_ROWS] = '{
        '{16'sh7FFF, 16'sh7FFF}, '{16'sh8000, 16'sh8000}, '{16'sh0000, 16'sh0000},
        '{16'shFFFF, 16'shFFFF}, '{16'sh0001, 16'sh0001}, '{16'sh7FFE, 16'sh7FFE},
        '{16'sh8001, 16'sh8001}, '{16'sh5555, 16'sh5555}, '{16'shAAAA, 16'shAAAA},
        '{16'sh00FF, 16'sh00FF}, '{16'shFF00, 16'shFF00}, '{16'sh0F0F, 16'sh0F0F},
        '{16'shF0F0, 16'shF0F0}, '{16'sh4000, 16'sh4000}, '{16'shC000, 16'shC000},
        '{16'sh3333, 16'sh3333}, '{16'shCCCC, 16'shCCCC}, '{16'sh1234, 16'sh1234},
        '{16'shEDCB, 16'shEDCB}, '{16'sh7FFF, 16'sh7FFF}, '{16'sh7FFF, 16'sh7FFF},
        '{16'sh8000, 16'sh8000}, '{16'sh8000, 16'sh8000}, '{16'sh0000, 16'sh0000},
        '{16'sh0100, 16'sh0100}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    pcm_t                   sample_in;
    logic                   out_valid;
    logic                   out_stall;
    pcm_t                   sample_out;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    cascaded_echo_delay_top #(
        .BLOCK_LEN    (BLOCK_LEN),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // ------------------------------------------------------------------
    // Echo predictor state: three delay rings, block indices, position in
    // block, the programmed registers and the copies latched at block start.
    // ------------------------------------------------------------------
    pcm_t        tap1_mem [RING_DEPTH];
    pcm_t        tap2_mem [RING_DEPTH];
    pcm_t        tap3_mem [RING_DEPTH];
    int unsigned wr_blk;
    int unsigned rd_blk;
    int unsigned blk_pos;
    int unsigned delay_reg;
    int unsigned decay_reg;
    int unsigned len_blk;
    int unsigned gain_blk;

    // Expected output samples, oldest first
    pcm_t        echo_expect [$];
    pcm_t        expected_out;
    int          mismatch_cnt;
    int          quiet_cycles;
    int          stall_left;
    bit          calm;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic pcm_t clip(input longint v);
        if (v > PCM_MAX)
            return pcm_t'(PCM_MAX);
        if (v < PCM_MIN)
            return pcm_t'(PCM_MIN);
        return pcm_t'(v);
    endfunction

    // Q1.15 gain with round-half-up; >>> floors negative products
    function automatic pcm_t apply_decay(input pcm_t v);
        longint prod;
        prod = longint'(v) * longint'(gain_blk) + (longint'(1) << (DECAY_FRAC - 1));
        return clip(prod >>> DECAY_FRAC);
    endfunction

    // Advances the predictor by one sample and returns the expected output.
    function automatic pcm_t next_echo_out(input pcm_t x);
        int unsigned wr_addr;
        int unsigned rd_addr;
        pcm_t        tap_a;
        pcm_t        tap_b;
        pcm_t        tap_c;
        pcm_t        mix;
        // block start: latch length and gain, fold both indices
        if (blk_pos == 0)
        begin
            len_blk = delay_reg;
            if (len_blk < MIN_BLOCKS)
                len_blk = MIN_BLOCKS;
            if (len_blk > MAX_BLOCKS)
                len_blk = MAX_BLOCKS;
            gain_blk = decay_reg;
            wr_blk   = wr_blk % len_blk;
            rd_blk   = rd_blk % len_blk;
        end
        wr_addr = wr_blk * BLOCK_LEN + blk_pos;
        rd_addr = rd_blk * BLOCK_LEN + blk_pos;
        if (wr_addr >= RING_DEPTH)
            wr_addr = 0;
        if (rd_addr >= RING_DEPTH)
            rd_addr = 0;
        tap_a = tap1_mem[rd_addr];
        tap_b = tap2_mem[rd_addr];
        tap_c = tap3_mem[rd_addr];
        mix = clip(longint'(x) + longint'(tap_a) + longint'(tap_b) + longint'(tap_c));
        // cascade: each stage feeds the next one a block-delay later
        tap2_mem[wr_addr] = apply_decay(tap_a);
        tap3_mem[wr_addr] = apply_decay(tap_b);
        tap1_mem[wr_addr] = apply_decay(x);
        blk_pos++;
        if (blk_pos >= BLOCK_LEN)
        begin
            blk_pos = 0;
            wr_blk++;
            rd_blk++;
        end
        return mix;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones; none in calm phases
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Full-range noise with extra weight on the rails and on small values
    function automatic pcm_t pick_sample();
        case ($urandom_range(0, 9))
            0: return pcm_t'(PCM_MAX);
            1: return pcm_t'(PCM_MIN);
            2: return pcm_t'($urandom_range(0, 64)) - pcm_t'(32);
            default: return pcm_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // One input transfer. A gap drops in_valid at the step of the previous
    // transfer; with no gap the next sample follows directly.
    task automatic feed_sample(input pcm_t din, input bit typed, input pcm_t want);
        int   gap;
        pcm_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= din;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = next_echo_out(din);
        echo_expect.push_back(typed ? want : predicted);
    endtask

    // Register write: one strobe cycle, then cfg_we low before the task returns
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_DELAY_BLOCKS)
            delay_reg = data[DELAY_W-1:0];
        else
            decay_reg = data[DECAY_W-1:0];
        @(posedge clk);
    endtask

    // Wait for every expected sample, then let the pipeline settle
    task automatic drain();
        while (echo_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: score each output transfer, then pick the next stall.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (echo_expect.size() == 0)
            begin
                mismatch_cnt++;
                $display("%0t: unexpected sample_out %0d, nothing pending",
                         $time, sample_out);
            end
            else
            begin
                expected_out = echo_expect.pop_front();
                if (sample_out !== expected_out)
                begin
                    mismatch_cnt++;
                    $display("%0t: sample_out expected %0d actual %0d",
                             $time, expected_out, sample_out);
                end
            end
        end
        // stall runs: many short, a few long, none in calm phases
        if (stall_left > 0)
            stall_left--;
        else if (calm || $urandom_range(0, 99) < 65)
            out_stall <= 1'b0;
        else
        begin
            out_stall  <= 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 2);
        end
    end

    // Watchdog: consecutive cycles with no transfer on either channel
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int          ph;
        int          n;
        int unsigned len_val;
        int unsigned decay_val;

        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample_in  = '0;
        out_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        calm       = 1'b0;
        stall_left = 0;
        mismatch_cnt = 0;

        for (n = 0; n < RING_DEPTH; n++)
        begin
            tap1_mem[n] = '0;
            tap2_mem[n] = '0;
            tap3_mem[n] = '0;
        end
        wr_blk    = 0;
        rd_blk    = 1;
        blk_pos   = 0;
        delay_reg = DELAY_RESET;
        decay_reg = DECAY_RESET;
        len_blk   = DELAY_RESET;
        gain_blk  = DECAY_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Warm-up at reset settings: rails, sign boundary, bit patterns.
        // in_stall holds through the RAM clear, so the first transfer waits.
        for (n = 0; n < WARM_ROWS; n++)
            feed_sample(WARM_TABLE[n].din, 1'b1, WARM_TABLE[n].want);
        in_valid <= 1'b0;
        drain();

        // Random phases. Writes land mid-block and only take effect at the next
        // block start. Latching phases: length 0 (clamped up) with decay above
        // one, length 1 with unity gain, length 255 (clamped down) with zero
        // gain, length 3 with random gain. The rest are overwritten unlatched.
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            calm = (ph % 3 == 2);
            case (ph)
                0: begin len_val = 129; decay_val = 40000; end
                1: begin len_val = 0;   decay_val = 65535; end
                2: begin len_val = 2;   decay_val = $urandom_range(0, 65535); end
                3: begin len_val = 1;   decay_val = 32768; end
                4: begin len_val = 128; decay_val = 16384; end
                5: begin len_val = 255; decay_val = 0; end
                6: begin
                    len_val   = $urandom_range(0, 255);
                    decay_val = $urandom_range(0, 65535);
                end
                default: begin len_val = 3; decay_val = $urandom_range(0, 65535); end
            endcase
            // upper byte of the length write is don't-care; toggle it anyway
            if ($urandom_range(0, 1))
            begin
                program_reg(REG_DELAY_BLOCKS,
                            {8'($urandom_range(0, 255)), 8'(len_val)});
                program_reg(REG_DECAY, 16'(decay_val));
            end
            else
            begin
                program_reg(REG_DECAY, 16'(decay_val));
                program_reg(REG_DELAY_BLOCKS,
                            {8'($urandom_range(0, 255)), 8'(len_val)});
            end
            for (n = 0; n < PHASE_ITEMS; n++)
                feed_sample(pick_sample(), 1'b0, '0);
            in_valid <= 1'b0;
            drain();
        end

        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cedly_pkg.sv
rtl/core/cedly_ram.sv
rtl/core/cascaded_echo_delay_top.sv
verif/cascaded_echo_delay_top_tb.sv
